>>> rtl/core/pfsa_pkg.sv
// Shared types and codes for the paged free-list slot allocator.
package pfsa_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OOM    = 3'd1,
    ST_NULL   = 3'd2,
    ST_DOUBLE = 3'd3,
    ST_BAD    = 3'd4
  } status_t;

  typedef struct packed {
    logic    load;
    logic    fill;
    logic    open_done;
    logic    pop_rd;
    logic    bit_rd;
    logic    commit_pop;
    logic    commit_push;
    logic    finish;
    status_t status;
  } pfsa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic present;
    logic bad_handle;
    logic empty;
    logic can_open;
    logic fill_last;
    logic bit_set;
  } pfsa_stat_t;

endpackage

>>> rtl/core/pfsa_ctrl.sv
// Controller state machine of the paged free-list slot allocator.
module pfsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pfsa_pkg::pfsa_stat_t stat,
  output pfsa_pkg::pfsa_cmd_t  cmd
);
  import pfsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_FILL,
    S_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    cmd.status = ST_OK;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (!stat.is_free) begin
          if (stat.empty && stat.can_open) begin
            state_nxt = S_FILL;
          end else if (stat.empty) begin
            cmd.finish = 1'b1;
            cmd.status = ST_OOM;
            state_nxt  = S_IDLE;
          end else begin
            cmd.pop_rd = 1'b1;
            state_nxt  = S_WAIT;
          end
        end else if (!stat.present) begin
          cmd.finish = 1'b1;
          cmd.status = ST_NULL;
          state_nxt  = S_IDLE;
        end else if (stat.bad_handle) begin
          cmd.finish = 1'b1;
          cmd.status = ST_BAD;
          state_nxt  = S_IDLE;
        end else begin
          cmd.bit_rd = 1'b1;
          state_nxt  = S_WAIT;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.fill_last) begin
          cmd.open_done = 1'b1;
          state_nxt     = S_ISSUE;
        end
      end
      S_WAIT: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
        if (!stat.is_free) begin
          cmd.commit_pop = 1'b1;
        end else if (stat.bit_set) begin
          cmd.commit_push = 1'b1;
        end else begin
          cmd.status = ST_DOUBLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> rtl/core/pfsa_datapath.sv
// Datapath of the paged free-list slot allocator: stack, allocation bits, counters.
module pfsa_datapath #(
  parameter int SLOTS_PER_PAGE = 64,
  parameter int MAX_PAGES      = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_command,
  input  logic                 in_handle_present,
  input  logic [9:0]           in_handle,
  input  pfsa_pkg::pfsa_cmd_t  cmd,
  output pfsa_pkg::pfsa_stat_t stat,
  output logic                 out_valid,
  output pfsa_pkg::status_t    out_status,
  output logic [9:0]           out_slot_number,
  output logic [10:0]          out_free_count,
  output logic [10:0]          out_total_count
);
  import pfsa_pkg::*;

  localparam int POOL = SLOTS_PER_PAGE * MAX_PAGES;
  localparam int AW   = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int CW   = $clog2(POOL + 1);
  localparam int PW   = $clog2(MAX_PAGES + 1);
  localparam int FW   = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;

  logic          cmd_r;
  logic          present_r;
  logic [9:0]    handle_r;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [PW-1:0] pages_r;
  logic [CW-1:0] total_r;
  logic [FW-1:0] fill_cnt_r;

  logic [AW-1:0] stack_mem [POOL];
  logic          bits_mem  [POOL];
  logic [AW-1:0] stack_q;
  logic          bit_q;

  logic          valid_r;
  status_t       status_r;
  logic [9:0]    slot_r;
  logic [10:0]   free_r;
  logic [10:0]   total_out_r;

  logic [AW-1:0] fill_addr;
  logic [AW-1:0] handle_addr;

  assign fill_addr   = AW'(total_r + CW'(fill_cnt_r));
  assign handle_addr = AW'(handle_r);

  always_comb begin
    depth_nxt = depth_r;
    if (cmd.open_done) begin
      depth_nxt = CW'(SLOTS_PER_PAGE);
    end else if (cmd.commit_pop) begin
      depth_nxt = depth_r - CW'(1);
    end else if (cmd.commit_push && (32'(depth_r) < 32'(POOL))) begin
      depth_nxt = depth_r + CW'(1);
    end
  end

  assign stat.is_free    = (cmd_r == CMD_FREE);
  assign stat.present    = present_r;
  assign stat.bad_handle = (32'(handle_r) >= 32'(total_r));
  assign stat.empty      = (depth_r == '0);
  assign stat.can_open   = (32'(pages_r) < 32'(MAX_PAGES));
  assign stat.fill_last  = (fill_cnt_r == FW'(SLOTS_PER_PAGE - 1));
  assign stat.bit_set    = bit_q;

  // free stack; it is empty while a page is opened
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      stack_mem[AW'(fill_cnt_r)] <= fill_addr;
    end else if (cmd.commit_push && (32'(depth_r) < 32'(POOL))) begin
      stack_mem[AW'(depth_r)] <= handle_addr;
    end
    if (cmd.pop_rd) begin
      stack_q <= stack_mem[AW'(depth_r - CW'(1))];
    end
  end

  // allocated bits; a page's bits are cleared as it is opened
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      bits_mem[fill_addr] <= 1'b0;
    end else if (cmd.commit_pop) begin
      bits_mem[stack_q] <= 1'b1;
    end else if (cmd.commit_push) begin
      bits_mem[handle_addr] <= 1'b0;
    end
    if (cmd.bit_rd) begin
      bit_q <= bits_mem[handle_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= '0;
      pages_r    <= '0;
      total_r    <= '0;
      fill_cnt_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      valid_r <= cmd.finish;
      if (cmd.open_done) begin
        pages_r    <= pages_r + PW'(1);
        total_r    <= total_r + CW'(SLOTS_PER_PAGE);
        fill_cnt_r <= '0;
      end else if (cmd.fill) begin
        fill_cnt_r <= fill_cnt_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_command;
      present_r <= in_handle_present;
      handle_r  <= in_handle;
    end
    if (cmd.finish) begin
      status_r    <= cmd.status;
      slot_r      <= cmd.commit_pop ? 10'(stack_q) : 10'd0;
      free_r      <= 11'(depth_nxt);
      total_out_r <= 11'(total_r);
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_slot_number = slot_r;
  assign out_free_count  = free_r;
  assign out_total_count = total_out_r;

endmodule

>>> rtl/core/paged_free_list_slot_allocator.sv
// Top level of the paged free-list slot allocator.
//
// Requests: drive in_command (0 allocate, 1 free), in_handle_present and
// in_handle with start; the request is taken at a clock edge where start is
// high and busy is low. Each request gives exactly one result, shown for one
// cycle with out_valid high: out_status, out_slot_number (allocate only),
// out_free_count and out_total_count. The receiver cannot stall, so a result
// is never held.
// Order: a request passes the issue state, where the free stack or the
// allocation bits are read into registers, and then the wait state; busy
// falls in the same cycle that out_valid rises, so a new request is taken
// only once the last is through. A null or bad handle, or out of memory,
// answers from the issue state without the wait state. An allocate that
// finds the stack empty with a page left opens that page first, one slot per cycle.
// Reset (rst_n low, synchronous): no pages open, stack empty, no result
// pending. The memories need no clearing pass; a page's allocation bits are
// cleared while it is opened.
module paged_free_list_slot_allocator #(
  parameter int SLOTS_PER_PAGE = 64,
  parameter int MAX_PAGES      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic        in_handle_present,
  input  logic [9:0]  in_handle,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_slot_number,
  output logic [10:0] out_free_count,
  output logic [10:0] out_total_count
);
  import pfsa_pkg::*;

  pfsa_cmd_t  cmd;
  pfsa_stat_t stat;
  status_t    status;

  pfsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  pfsa_datapath #(
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
    .MAX_PAGES      (MAX_PAGES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_command),
    .in_handle_present (in_handle_present),
    .in_handle         (in_handle),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (status),
    .out_slot_number   (out_slot_number),
    .out_free_count    (out_free_count),
    .out_total_count   (out_total_count)
  );

  assign out_status = status;

endmodule
